// ----- hw/rtl/pmrp_pkg.sv -----
// Package: shared constants and types for the mailbox parasite register port.
package pmrp_pkg;
  localparam int LONG_QUEUE_DEPTH = 24;
  localparam int LQ_AW = (LONG_QUEUE_DEPTH > 1) ? $clog2(LONG_QUEUE_DEPTH) : 1;
  localparam int LQ_CW = $clog2(LONG_QUEUE_DEPTH + 1);

  localparam logic [2:0] OP_PREAD = 3'd0;
  localparam logic [2:0] OP_PWRITE = 3'd1;
  localparam logic [2:0] OP_CEND = 3'd2;
  localparam logic [2:0] OP_HPUT = 3'd3;
  localparam logic [2:0] OP_HTAKE = 3'd4;
  localparam logic [2:0] OP_HFLAGS = 3'd5;

  localparam logic [7:0] FLG_I = 8'h02;
  localparam logic [7:0] FLG_J = 8'h04;
  localparam logic [7:0] FLG_M = 8'h08;
  localparam logic [7:0] FLG_V = 8'h10;

  typedef struct packed {
    logic       we;
    logic [LQ_AW-1:0] waddr;
    logic [7:0] wdata;
    logic [LQ_AW-1:0] raddr;
  } lq_ctl_t;
endpackage

// ----- hw/rtl/parasite_mailbox_register_port.sv -----
// Top level: mailbox parasite register port with plain host side model.
// One transaction per cycle while in_stall is low: each accepted item is processed in
// the cycle it is accepted and its result is registered into the output register; the
// long-queue RAM is read ahead at the head pointer so a host take sees it at once.
module parasite_mailbox_register_port
  import pmrp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [2:0] opcode,
  input  logic [2:0] reg_offset,
  input  logic [7:0] data_in,
  output logic out_valid,
  input  logic out_stall,
  output logic [7:0] read_data,
  output logic irq_out,
  output logic nmi_out
);
  logic [5:0] ctl;
  logic [7:0] dlv [3];
  logic [2:0] dlr;
  logic [7:0] dps [2];
  logic dp_head;
  logic [1:0] dp_count;
  logic [LQ_AW-1:0] ul_head, ul_tail;
  logic [LQ_CW-1:0] ul_count;
  logic [7:0] ulv [2];
  logic [1:0] ulr;
  logic [7:0] ups [2];
  logic up_head, up_tail;
  logic [1:0] up_count;
  logic [3:0] pend;
  logic [7:0] cache [4];
  logic [7:0] hbl;
  logic nmi_prev, nmi_edge;
  logic [7:0] lq_rdata;
  lq_ctl_t lq;
  logic [7:0] lq_rd_q;
  logic byp;
  logic [7:0] lq_head_data;

  logic go;
  assign in_stall = out_valid && out_stall;
  assign go = in_valid && !in_stall;

  // next-state values
  logic [5:0] ctl_next;
  logic [7:0] dlv_next [3];
  logic [2:0] dlr_next;
  logic [7:0] dps_next [2];
  logic dp_head_next, up_head_next, up_tail_next;
  logic [1:0] dp_count_next, up_count_next;
  logic [LQ_AW-1:0] ul_head_next, ul_tail_next;
  logic [LQ_CW-1:0] ul_count_next;
  logic [7:0] ulv_next [2];
  logic [1:0] ulr_next;
  logic [7:0] ups_next [2];
  logic [3:0] pend_next;
  logic [7:0] cache_next [4];
  logic [7:0] hbl_next;
  logic [7:0] rd;
  logic [1:0] thr;
  logic lvl;
  logic [1:0] ch;
  logic [1:0] li, ci;

  function automatic logic [LQ_AW-1:0] lq_inc(input logic [LQ_AW-1:0] p);
    return (p == LQ_AW'(LONG_QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    ctl_next = ctl; dlv_next = dlv; dlr_next = dlr; dps_next = dps;
    dp_head_next = dp_head; dp_count_next = dp_count;
    ul_head_next = ul_head; ul_tail_next = ul_tail; ul_count_next = ul_count;
    ulv_next = ulv; ulr_next = ulr; ups_next = ups;
    up_head_next = up_head; up_tail_next = up_tail; up_count_next = up_count;
    pend_next = pend; cache_next = cache; hbl_next = hbl;
    rd = '0;
    lq.we = 1'b0; lq.waddr = ul_tail; lq.wdata = data_in;
    thr = ctl[4] ? 2'd2 : 2'd1;
    ch = reg_offset[2:1];
    li = (reg_offset == 3'd1) ? 2'd0 : (reg_offset == 3'd3) ? 2'd1 : 2'd2;
    ci = (reg_offset == 3'd1) ? 2'd0 : (reg_offset == 3'd3) ? 2'd1 : 2'd3;
    case (opcode)
      OP_PREAD: begin
        case (reg_offset)
          3'd0: rd = {dlr[0], ul_count < LQ_CW'(LONG_QUEUE_DEPTH), ctl};
          3'd2: rd = {dlr[1], !ulr[0], 6'h3F};
          3'd6: rd = {dlr[2], !ulr[1], 6'h3F};
          3'd4: rd = {dp_count >= thr, up_count < thr,
                      (dp_count >= thr) || (up_count < thr), 5'h1F};
          3'd5: begin
            if (!pend[2]) begin
              if (dp_count != 0) begin
                cache_next[2] = dps[dp_head];
                pend_next[2] = 1'b1;
              end else cache_next[2] = hbl;
            end
            rd = cache_next[2];
          end
          default: begin
            // odd latch channels: capture now, clear ready at cycle end
            if (!pend[ci]) begin
              cache_next[ci] = dlv[li];
              if (dlr[li]) pend_next[ci] = 1'b1;
            end
            rd = cache_next[ci];
          end
        endcase
      end
      OP_PWRITE: begin
        case (reg_offset)
          3'd1: if (ul_count < LQ_CW'(LONG_QUEUE_DEPTH)) begin
            lq.we = 1'b1;
            ul_tail_next = lq_inc(ul_tail);
            ul_count_next = ul_count + 1'b1;
          end
          3'd3: begin ulv_next[0] = data_in; ulr_next[0] = 1'b1; end
          3'd7: begin ulv_next[1] = data_in; ulr_next[1] = 1'b1; end
          3'd5: if (up_count < 2'd2) begin
            ups_next[up_tail] = data_in;
            up_tail_next = !up_tail;
            up_count_next = up_count + 1'b1;
          end
          default: ;
        endcase
      end
      OP_CEND: begin
        if (pend[0]) dlr_next[0] = 1'b0;
        if (pend[1]) dlr_next[1] = 1'b0;
        if (pend[3]) dlr_next[2] = 1'b0;
        if (pend[2] && dp_count != 0) begin
          dp_head_next = !dp_head;
          dp_count_next = dp_count - 1'b1;
        end
        pend_next = '0;
      end
      OP_HPUT: begin
        hbl_next = data_in;
        if (ch == 2'd2) begin
          if (dp_count < 2'd2) begin
            dps_next[dp_head ^ dp_count[0]] = data_in;
            dp_count_next = dp_count + 1'b1;
          end
        end else begin
          dlv_next[(ch == 2'd3) ? 2'd2 : ch] = data_in;
          dlr_next[(ch == 2'd3) ? 2'd2 : ch] = 1'b1;
        end
      end
      OP_HTAKE: begin
        if (ch == 2'd0) begin
          if (ul_count != 0) begin
            rd = lq_head_data;
            ul_head_next = lq_inc(ul_head);
            ul_count_next = ul_count - 1'b1;
          end
        end else if (ch == 2'd2) begin
          if (up_count != 0) begin
            rd = ups[up_head];
            up_head_next = !up_head;
            up_count_next = up_count - 1'b1;
          end
        end else begin
          rd = ulv[ch[1]];
          ulr_next[ch[1]] = 1'b0;
        end
      end
      OP_HFLAGS: ctl_next = data_in[5:0];
      default: ;
    endcase
    lq.we = lq.we && go;
    // prefetch the head entry for the next transaction
    lq.raddr = go ? ul_head_next : ul_head;
    thr = ctl_next[4] ? 2'd2 : 2'd1;
    lvl = ctl_next[3] && ((dp_count_next >= thr) || (up_count_next < thr));
  end

  pmrp_ram #(.WIDTH(8), .DEPTH(LONG_QUEUE_DEPTH)) u_lq (
    .clk(clk), .we(lq.we), .waddr(lq.waddr), .wdata(lq.wdata),
    .raddr(lq.raddr), .rdata(lq_rdata)
  );

  // bypass: a write at the head while empty must be seen by the next take
  always_ff @(posedge clk) begin
    byp <= lq.we && (lq.waddr == lq.raddr);
    lq_rd_q <= lq.wdata;
  end
  assign lq_head_data = byp ? lq_rd_q : lq_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0; dlv <= '{default: '0}; dlr <= '0; dps <= '{default: '0};
      dp_head <= 1'b0; dp_count <= '0;
      ul_head <= '0; ul_tail <= '0; ul_count <= '0;
      ulv <= '{default: '0}; ulr <= '0; ups <= '{default: '0};
      up_head <= 1'b0; up_tail <= 1'b1; up_count <= 2'd1;
      pend <= '0; cache <= '{default: '0}; hbl <= '0;
      nmi_prev <= 1'b0; nmi_edge <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (go) begin
        ctl <= ctl_next; dlv <= dlv_next; dlr <= dlr_next; dps <= dps_next;
        dp_head <= dp_head_next; dp_count <= dp_count_next;
        ul_head <= ul_head_next; ul_tail <= ul_tail_next; ul_count <= ul_count_next;
        ulv <= ulv_next; ulr <= ulr_next; ups <= ups_next;
        up_head <= up_head_next; up_tail <= up_tail_next; up_count <= up_count_next;
        pend <= pend_next; cache <= cache_next; hbl <= hbl_next;
        nmi_prev <= lvl;
        nmi_edge <= lvl && (nmi_edge || !nmi_prev);
        read_data <= rd;
        irq_out <= (ctl_next[1] && dlr_next[0]) || (ctl_next[2] && dlr_next[2]);
        nmi_out <= lvl && (nmi_edge || !nmi_prev);
      end
      if (go) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end
endmodule

// ----- hw/rtl/pmrp_ram.sv -----
// Generic single-write, registered-read RAM.
module pmrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 24
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
